// ===== rtl/pdr_pkg.sv =====
`timescale 1ns / 1ps
// pdr_pkg: widths, codes, register map and control structs of the
// differential-drive PID block. No dependencies.
package pdr_pkg;

    localparam int DATA_W    = 16;
    localparam int KD_W      = 24;
    localparam int CFG_W     = KD_W;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 15;
    localparam int SUM_W     = 19;
    localparam int DUTY_W    = 12;

    // +100 percent in Q8.8
    localparam logic signed [DATA_W-1:0] FULL_SCALE = 16'sd25600;

    typedef enum logic [1:0] {
        ACT_RAMP = 2'd0,
        ACT_PID  = 2'd1,
        ACT_SET  = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP         = 3'd0,
        CFG_KI         = 3'd1,
        CFG_KD         = 3'd2,
        CFG_P_LIMIT    = 3'd3,
        CFG_I_LIMIT    = 3'd4,
        CFG_D_LIMIT    = 3'd5,
        CFG_ACCEL_STEP = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [DATA_W-1:0] kp;
        logic [DATA_W-1:0] ki;
        logic [KD_W-1:0]   kd;
        logic [DATA_W-1:0] p_limit;
        logic [DATA_W-1:0] i_limit;
        logic [DATA_W-1:0] d_limit;
        logic [STEP_W-1:0] accel_step;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        kp:         16'd512,
        ki:         16'd256,
        kd:         24'd640000,
        p_limit:    16'd512,
        i_limit:    16'd512,
        d_limit:    16'd512,
        accel_step: 15'd2560
    };

    // pipeline advance and item kind for the PID term stages
    typedef struct packed {
        logic adv_b;
        logic adv_c;
        logic a_pid;
        logic b_pid;
    } t_pid_ctl;

    // final stage: advance and the item that moves into the result register
    typedef struct packed {
        logic    adv_o;
        t_action action;
        logic    motor_sel;
    } t_drive_ctl;

endpackage

// ===== rtl/pdr_pid.sv =====
`timescale 1ns / 1ps
// pdr_pid: PID term stages. Registers the three gain products, then rounds,
// clamps and sums the P, I and D terms. Holds the integral and previous error. Uses pdr_pkg.
module pdr_pid import pdr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_pid_ctl                 i_ctl,
    input  t_cfg                     i_cfg,
    input  logic signed [DATA_W-1:0] i_rate_setpoint,
    input  logic signed [DATA_W-1:0] i_rate_measured,
    output logic signed [SUM_W-1:0]  o_sum
);

    localparam int ERR_W    = DATA_W + 1;
    localparam int DIFF_W   = ERR_W + 1;
    localparam int PROD_W   = 2 * ERR_W;
    localparam int PROD_D_W = DIFF_W + KD_W + 1;
    localparam int RND_W    = PROD_D_W - 7;

    // divide by 256, round to nearest with ties away from zero
    function automatic logic signed [RND_W-1:0] rnd_q8(
        input logic signed [PROD_D_W-1:0] x
    );
        logic [PROD_D_W-1:0] mag;
        logic [PROD_D_W-1:0] q;
        mag = x[PROD_D_W-1] ? PROD_D_W'(-x) : PROD_D_W'(x);
        q   = (mag + PROD_D_W'(128)) >> 8;
        return x[PROD_D_W-1] ? -$signed(q[RND_W-1:0]) : $signed(q[RND_W-1:0]);
    endfunction

    function automatic logic signed [ERR_W-1:0] clamp_lim(
        input logic signed [RND_W-1:0] x,
        input logic [DATA_W-1:0]       lim
    );
        logic signed [RND_W-1:0] hi;
        logic signed [RND_W-1:0] lo;
        hi = $signed(RND_W'(lim));
        lo = -hi;
        if (x > hi) begin
            return hi[ERR_W-1:0];
        end else if (x < lo) begin
            return lo[ERR_W-1:0];
        end else begin
            return x[ERR_W-1:0];
        end
    endfunction

    logic signed [ERR_W-1:0]    err;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   n_prod_p;
    logic signed [PROD_W-1:0]   n_prod_i;
    logic signed [PROD_D_W-1:0] n_prod_d;
    logic signed [PROD_W-1:0]   r_prod_p;
    logic signed [PROD_W-1:0]   r_prod_i;
    logic signed [PROD_D_W-1:0] r_prod_d;
    logic signed [ERR_W-1:0]    r_prev_err;
    logic signed [ERR_W-1:0]    r_integ;
    logic signed [RND_W-1:0]    i_acc;
    logic signed [ERR_W-1:0]    p_term;
    logic signed [ERR_W-1:0]    n_integ;
    logic signed [ERR_W-1:0]    d_term;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [SUM_W-1:0]    r_sum;

    assign err  = ERR_W'(i_rate_setpoint) - ERR_W'(i_rate_measured);
    assign diff = DIFF_W'(err) - DIFF_W'(r_prev_err);

    assign n_prod_p = err * $signed({1'b0, i_cfg.kp});
    assign n_prod_i = err * $signed({1'b0, i_cfg.ki});
    assign n_prod_d = diff * $signed({1'b0, i_cfg.kd});

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_b) begin
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
        end
    end

    // previous error advances with PID items as they enter the product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
        end else if (i_ctl.adv_b && i_ctl.a_pid) begin
            r_prev_err <= err;
        end
    end

    assign p_term  = clamp_lim(rnd_q8(PROD_D_W'(r_prod_p)), i_cfg.p_limit);
    assign i_acc   = RND_W'(r_integ) + rnd_q8(PROD_D_W'(r_prod_i));
    assign n_integ = clamp_lim(i_acc, i_cfg.i_limit);
    assign d_term  = clamp_lim(rnd_q8(r_prod_d), i_cfg.d_limit);
    assign n_sum   = SUM_W'(p_term) + SUM_W'(n_integ) + SUM_W'(d_term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_ctl.adv_c && i_ctl.b_pid) begin
            r_integ <= n_integ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_c) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== rtl/pdr_drive.sv =====
`timescale 1ns / 1ps
// pdr_drive: motor stage. Scales the PID sum by 1/50 into the targets, applies
// set-target and ramp items, and registers the reported duty, direction and targets. Uses pdr_pkg.
module pdr_drive import pdr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_drive_ctl               i_ctl,
    input  logic [STEP_W-1:0]        i_accel_step,
    input  logic signed [DATA_W-1:0] i_target_percent,
    input  logic signed [SUM_W-1:0]  i_sum,
    output logic [DUTY_W-1:0]        o_left_duty,
    output logic                     o_left_forward,
    output logic [DUTY_W-1:0]        o_right_duty,
    output logic                     o_right_forward,
    output logic signed [DATA_W-1:0] o_left_goal,
    output logic signed [DATA_W-1:0] o_right_goal
);

    localparam int MAG_W       = SUM_W - 1;
    localparam int DIV_SHIFT   = 24;
    localparam int DIV_MULT_W  = 19;
    localparam int DIV_PROD_W  = MAG_W + DIV_MULT_W;
    localparam int QUOT_W      = DIV_PROD_W - DIV_SHIFT;
    localparam int WIDE_W      = DATA_W + 2;
    localparam int DUTY_SUM_W  = DATA_W + 6;
    // ceil(2^24 / 50): exact floor(n / 50) for every n below 2^18
    localparam logic [DIV_MULT_W-1:0] DIV50_MULT = 19'd335545;
    localparam logic [MAG_W-1:0]      DIV50_HALF = 18'd25;

    // step toward the goal by at most step, never passing it
    function automatic logic signed [DATA_W-1:0] ramp(
        input logic signed [DATA_W-1:0] cmd,
        input logic signed [DATA_W-1:0] goal,
        input logic [STEP_W-1:0]        step
    );
        logic signed [WIDE_W-1:0] s;
        logic signed [WIDE_W-1:0] up;
        logic signed [WIDE_W-1:0] dn;
        logic signed [WIDE_W-1:0] g;
        s  = $signed({{(WIDE_W-STEP_W){1'b0}}, step});
        up = WIDE_W'(cmd) + s;
        dn = WIDE_W'(cmd) - s;
        g  = WIDE_W'(goal);
        if (cmd < goal) begin
            return (up < g) ? up[DATA_W-1:0] : goal;
        end else if (cmd > goal) begin
            return (dn > g) ? dn[DATA_W-1:0] : goal;
        end else begin
            return cmd;
        end
    endfunction

    // |cmd| * 40 / 256, rounded half up
    function automatic logic [DUTY_W-1:0] duty_of(input logic signed [DATA_W-1:0] cmd);
        logic [DATA_W-1:0]     mag;
        logic [DUTY_SUM_W-1:0] scaled;
        mag    = cmd[DATA_W-1] ? DATA_W'(-cmd) : DATA_W'(cmd);
        scaled = DUTY_SUM_W'({mag, 5'b0}) + DUTY_SUM_W'({mag, 3'b0}) + DUTY_SUM_W'(128);
        return scaled[DUTY_W+7:8];
    endfunction

    logic [MAG_W-1:0]         sum_mag;
    logic [MAG_W-1:0]         dividend;
    logic [DIV_PROD_W-1:0]    div_prod;
    logic [DATA_W-1:0]        u_mag;
    logic signed [DATA_W-1:0] pid_right;
    logic signed [DATA_W-1:0] pid_left;
    logic signed [DATA_W-1:0] set_v;

    logic signed [DATA_W-1:0] r_left_cmd;
    logic signed [DATA_W-1:0] r_right_cmd;
    logic signed [DATA_W-1:0] r_left_tgt;
    logic signed [DATA_W-1:0] r_right_tgt;
    logic signed [DATA_W-1:0] n_left_cmd;
    logic signed [DATA_W-1:0] n_right_cmd;
    logic signed [DATA_W-1:0] n_left_tgt;
    logic signed [DATA_W-1:0] n_right_tgt;

    logic [DUTY_W-1:0]        r_left_duty;
    logic                     r_left_fwd;
    logic [DUTY_W-1:0]        r_right_duty;
    logic                     r_right_fwd;
    logic signed [DATA_W-1:0] r_left_goal;
    logic signed [DATA_W-1:0] r_right_goal;

    // u = sum / 50, ties away from zero; |u| stays under 4000, so no full-scale clamp
    assign sum_mag  = i_sum[SUM_W-1] ? MAG_W'(-i_sum) : MAG_W'(i_sum);
    assign dividend = sum_mag + DIV50_HALF;
    assign div_prod = DIV_PROD_W'(dividend) * DIV_PROD_W'(DIV50_MULT);
    assign u_mag    = DATA_W'(div_prod[DIV_PROD_W-1 -: QUOT_W]);
    assign pid_right = i_sum[SUM_W-1] ? -u_mag : u_mag;
    assign pid_left  = i_sum[SUM_W-1] ? u_mag : -u_mag;

    always_comb begin
        if (i_target_percent > FULL_SCALE) begin
            set_v = FULL_SCALE;
        end else if (i_target_percent < -FULL_SCALE) begin
            set_v = -FULL_SCALE;
        end else begin
            set_v = i_target_percent;
        end
    end

    always_comb begin
        n_left_cmd  = r_left_cmd;
        n_right_cmd = r_right_cmd;
        n_left_tgt  = r_left_tgt;
        n_right_tgt = r_right_tgt;
        unique case (i_ctl.action)
            ACT_RAMP: begin
                n_left_cmd  = ramp(r_left_cmd, r_left_tgt, i_accel_step);
                n_right_cmd = ramp(r_right_cmd, r_right_tgt, i_accel_step);
            end
            ACT_PID: begin
                n_left_tgt  = pid_left;
                n_right_tgt = pid_right;
            end
            ACT_SET: begin
                if (i_ctl.motor_sel) begin
                    n_right_tgt = -set_v;
                end else begin
                    n_left_tgt = set_v;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_cmd  <= '0;
            r_right_cmd <= '0;
            r_left_tgt  <= '0;
            r_right_tgt <= '0;
        end else if (i_ctl.adv_o) begin
            r_left_cmd  <= n_left_cmd;
            r_right_cmd <= n_right_cmd;
            r_left_tgt  <= n_left_tgt;
            r_right_tgt <= n_right_tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_o) begin
            r_left_duty  <= duty_of(n_left_cmd);
            r_left_fwd   <= (n_left_cmd > 0);
            r_right_duty <= duty_of(n_right_cmd);
            r_right_fwd  <= (n_right_cmd > 0);
            r_left_goal  <= n_left_tgt;
            r_right_goal <= n_right_tgt;
        end
    end

    assign o_left_duty     = r_left_duty;
    assign o_left_forward  = r_left_fwd;
    assign o_right_duty    = r_right_duty;
    assign o_right_forward = r_right_fwd;
    assign o_left_goal     = r_left_goal;
    assign o_right_goal    = r_right_goal;

    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left_cmd <= FULL_SCALE && r_left_cmd >= -FULL_SCALE &&
        r_right_cmd <= FULL_SCALE && r_right_cmd >= -FULL_SCALE)
        else $error("motor command outside full scale");

    a_left_no_overshoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.adv_o && i_ctl.action == ACT_RAMP && r_left_cmd <= r_left_tgt
        |=> r_left_cmd <= r_left_tgt)
        else $error("left ramp passed its target");

    a_right_no_overshoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.adv_o && i_ctl.action == ACT_RAMP && r_right_cmd >= r_right_tgt
        |=> r_right_cmd >= r_right_tgt)
        else $error("right ramp passed its target");

endmodule

// ===== rtl/pid_differential_drive_ramp_top.sv =====
`timescale 1ns / 1ps
// pid_differential_drive_ramp_top: angular-rate PID with slew-limited motor
// commands for a two-wheel drive. Uses pdr_pkg, pdr_pid and pdr_drive.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item: ramp tick,
//   PID update or set-target. Output channel (o_out_valid / i_out_stall)
//   returns exactly one result per item, in order: duty and direction of
//   both motors after the item, plus both current targets.
//   A transfer happens on a rising edge with valid high and stall low.
//   Pipeline: input register, gain products, term sum, result register.
//   The result of an item passes through those four registers in order;
//   one item per cycle is sustained while i_out_stall stays low.
//   While i_out_stall holds a result, earlier empty stages keep filling;
//   o_in_stall rises only once all four stages hold items.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data),
//   one register per edge; write it only while no item is in flight.
//   Indexes past the last register are ignored.
//   Reset (synchronous, active low) restores the register defaults, clears
//   integral, previous error, commands and targets, and empties the pipeline.
module pid_differential_drive_ramp_top import pdr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_action,
    input  logic signed [DATA_W-1:0] i_rate_setpoint,
    input  logic signed [DATA_W-1:0] i_rate_measured,
    input  logic                     i_motor_select,
    input  logic signed [DATA_W-1:0] i_target_percent,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [DUTY_W-1:0]        o_left_duty,
    output logic                     o_left_forward,
    output logic [DUTY_W-1:0]        o_right_duty,
    output logic                     o_right_forward,
    output logic signed [DATA_W-1:0] o_left_goal,
    output logic signed [DATA_W-1:0] o_right_goal,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    t_cfg r_cfg;

    logic r_a_vld;
    logic r_b_vld;
    logic r_c_vld;
    logic r_o_vld;
    logic adv_b;
    logic adv_c;
    logic adv_o;
    logic in_take;

    logic [1:0]               r_a_action;
    logic signed [DATA_W-1:0] r_a_setpoint;
    logic signed [DATA_W-1:0] r_a_measured;
    logic                     r_a_sel;
    logic signed [DATA_W-1:0] r_a_target;
    logic [1:0]               r_b_action;
    logic                     r_b_sel;
    logic signed [DATA_W-1:0] r_b_target;
    logic [1:0]               r_c_action;
    logic                     r_c_sel;
    logic signed [DATA_W-1:0] r_c_target;

    logic signed [SUM_W-1:0] pid_sum;
    t_pid_ctl                pid_ctl;
    t_drive_ctl              drive_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KP:         r_cfg.kp         <= i_cfg_data[DATA_W-1:0];
                CFG_KI:         r_cfg.ki         <= i_cfg_data[DATA_W-1:0];
                CFG_KD:         r_cfg.kd         <= i_cfg_data[KD_W-1:0];
                CFG_P_LIMIT:    r_cfg.p_limit    <= i_cfg_data[DATA_W-1:0];
                CFG_I_LIMIT:    r_cfg.i_limit    <= i_cfg_data[DATA_W-1:0];
                CFG_D_LIMIT:    r_cfg.d_limit    <= i_cfg_data[DATA_W-1:0];
                CFG_ACCEL_STEP: r_cfg.accel_step <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage advances when the next one is empty or advancing itself
    always_comb begin
        adv_o   = r_c_vld && (!r_o_vld || !i_out_stall);
        adv_c   = r_b_vld && (!r_c_vld || adv_o);
        adv_b   = r_a_vld && (!r_b_vld || adv_c);
        in_take = i_in_valid && (!r_a_vld || adv_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_a_vld <= in_take || (r_a_vld && !adv_b);
            r_b_vld <= adv_b || (r_b_vld && !adv_c);
            r_c_vld <= adv_c || (r_c_vld && !adv_o);
            r_o_vld <= adv_o || (r_o_vld && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_action   <= i_action;
            r_a_setpoint <= i_rate_setpoint;
            r_a_measured <= i_rate_measured;
            r_a_sel      <= i_motor_select;
            r_a_target   <= i_target_percent;
        end
        if (adv_b) begin
            r_b_action <= r_a_action;
            r_b_sel    <= r_a_sel;
            r_b_target <= r_a_target;
        end
        if (adv_c) begin
            r_c_action <= r_b_action;
            r_c_sel    <= r_b_sel;
            r_c_target <= r_b_target;
        end
    end

    assign pid_ctl.adv_b = adv_b;
    assign pid_ctl.adv_c = adv_c;
    assign pid_ctl.a_pid = (r_a_action == ACT_PID);
    assign pid_ctl.b_pid = (r_b_action == ACT_PID);

    pdr_pid u_pid (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (pid_ctl),
        .i_cfg           (r_cfg),
        .i_rate_setpoint (r_a_setpoint),
        .i_rate_measured (r_a_measured),
        .o_sum           (pid_sum)
    );

    assign drive_ctl.adv_o     = adv_o;
    assign drive_ctl.action    = t_action'(r_c_action);
    assign drive_ctl.motor_sel = r_c_sel;

    pdr_drive u_drive (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (drive_ctl),
        .i_accel_step     (r_cfg.accel_step),
        .i_target_percent (r_c_target),
        .i_sum            (pid_sum),
        .o_left_duty      (o_left_duty),
        .o_left_forward   (o_left_forward),
        .o_right_duty     (o_right_duty),
        .o_right_forward  (o_right_forward),
        .o_left_goal      (o_left_goal),
        .o_right_goal     (o_right_goal)
    );

    assign o_in_stall  = r_a_vld && !adv_b;
    assign o_out_valid = r_o_vld;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_b_vld && r_c_vld && r_o_vld && i_out_stall)
        else $error("input stalled with a free pipeline stage");

    a_result_from_sum_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_vld) |-> $past(r_c_vld))
        else $error("result appeared without an item in the sum stage");

    a_sum_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld && r_o_vld && i_out_stall |=> r_c_vld)
        else $error("sum stage dropped an item behind a stalled result");

endmodule

// ===== tb/tb_pid_differential_drive_ramp_top.sv =====
`timescale 1ns / 1ps
// tb_pid_differential_drive_ramp_top: self-checking bench for the differential-drive
// PID with slew-limited commands. Depends on pdr_pkg and pid_differential_drive_ramp_top.
module tb_pid_differential_drive_ramp_top;
    import pdr_pkg::*;

    localparam logic [1:0]           ACT_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd7;
    localparam longint               DUTY_PER_PCT = 40;
    localparam longint               RATE_DIV     = 50;
    localparam longint               PCT_MAX      = 25600;
    localparam int                   QUIET_LIMIT  = 2000;
    localparam int                   SETTLE_CYC   = 8;
    localparam int                   N_PHASES     = 8;
    localparam int                   PHASE_ITEMS  = 163;

    typedef struct {
        logic [1:0]               action;
        logic signed [DATA_W-1:0] setpoint;
        logic signed [DATA_W-1:0] measured;
        logic                     sel;
        logic signed [DATA_W-1:0] target;
    } t_drive_item;

    typedef struct {
        logic [DUTY_W-1:0]        left_duty;
        logic                     left_fwd;
        logic [DUTY_W-1:0]        right_duty;
        logic                     right_fwd;
        logic signed [DATA_W-1:0] left_goal;
        logic signed [DATA_W-1:0] right_goal;
    } t_drive_report;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_action = '0;
    logic signed [DATA_W-1:0] i_rate_setpoint = '0;
    logic signed [DATA_W-1:0] i_rate_measured = '0;
    logic                     i_motor_select = 1'b0;
    logic signed [DATA_W-1:0] i_target_percent = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [DUTY_W-1:0]        o_left_duty;
    logic                     o_left_forward;
    logic [DUTY_W-1:0]        o_right_duty;
    logic                     o_right_forward;
    logic signed [DATA_W-1:0] o_left_goal;
    logic signed [DATA_W-1:0] o_right_goal;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [CFG_W-1:0]         i_cfg_data = '0;

    pid_differential_drive_ramp_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_rate_setpoint (i_rate_setpoint),
        .i_rate_measured (i_rate_measured),
        .i_motor_select  (i_motor_select),
        .i_target_percent(i_target_percent),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_left_duty     (o_left_duty),
        .o_left_forward  (o_left_forward),
        .o_right_duty    (o_right_duty),
        .o_right_forward (o_right_forward),
        .o_left_goal     (o_left_goal),
        .o_right_goal    (o_right_goal),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // drive model: registers and state
    t_cfg                     cfg_model = CFG_RESET;
    logic signed [16:0]       integ_term = '0;
    logic signed [16:0]       last_err = '0;
    logic signed [DATA_W-1:0] left_cmd = '0;
    logic signed [DATA_W-1:0] right_cmd = '0;
    logic signed [DATA_W-1:0] left_tgt = '0;
    logic signed [DATA_W-1:0] right_tgt = '0;

    t_drive_item   pending_items[$];
    t_drive_report due_reports[$];
    logic          in_fire = 1'b0;
    int            send_idle_pct = 0;
    int            stall_pct = 0;
    int            err_count = 0;
    int            item_count = 0;
    int            report_count = 0;

    function automatic longint div_round(input longint x, input longint d);
        longint mag;
        mag = (x < 0) ? -x : x;
        mag = (mag + d / 2) / d;
        return (x < 0) ? -mag : mag;
    endfunction

    function automatic longint sat(input longint x, input longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    function automatic logic signed [DATA_W-1:0] slew(input logic signed [DATA_W-1:0] cmd,
                                                     input logic signed [DATA_W-1:0] goal);
        longint c, g, s;
        c = cmd;
        g = goal;
        s = longint'(cfg_model.accel_step);
        if (c < g) c = (c + s < g) ? c + s : g;
        if (c > g) c = (c - s > g) ? c - s : g;
        return DATA_W'(c);
    endfunction

    function automatic logic [DUTY_W-1:0] duty_of(input logic signed [DATA_W-1:0] cmd);
        longint m;
        m = cmd;
        if (m < 0) m = -m;
        return DUTY_W'((m * DUTY_PER_PCT + 128) / 256);
    endfunction

    // apply one item to the drive model and return the report it produces
    function automatic t_drive_report step_drive_model(input t_drive_item it);
        t_drive_report r;
        longint err, p, i, d, u, v;
        if (it.action == ACT_RAMP) begin
            right_cmd = slew(right_cmd, right_tgt);
            left_cmd  = slew(left_cmd, left_tgt);
        end else if (it.action == ACT_PID) begin
            err = longint'(it.setpoint) - longint'(it.measured);
            p = sat(div_round(err * longint'(cfg_model.kp), 256), longint'(cfg_model.p_limit));
            i = sat(longint'(integ_term) + div_round(err * longint'(cfg_model.ki), 256),
                    longint'(cfg_model.i_limit));
            d = sat(div_round((err - longint'(last_err)) * longint'(cfg_model.kd), 256),
                    longint'(cfg_model.d_limit));
            u = div_round(p + i + d, RATE_DIV);
            integ_term = 17'(i);
            last_err   = 17'(err);
            right_tgt  = DATA_W'(sat(u, PCT_MAX));
            left_tgt   = DATA_W'(sat(-u, PCT_MAX));
        end else if (it.action == ACT_SET) begin
            v = sat(longint'(it.target), PCT_MAX);
            if (!it.sel) left_tgt = DATA_W'(v);
            else right_tgt = DATA_W'(-v);
        end
        r.left_duty  = duty_of(left_cmd);
        r.left_fwd   = (left_cmd > 0);
        r.right_duty = duty_of(right_cmd);
        r.right_fwd  = (right_cmd > 0);
        r.left_goal  = left_tgt;
        r.right_goal = right_tgt;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_count++;
        end
    endfunction

    function automatic void push_item(input logic [1:0] action,
                                      input logic signed [DATA_W-1:0] sp,
                                      input logic signed [DATA_W-1:0] meas,
                                      input logic sel,
                                      input logic signed [DATA_W-1:0] tgt);
        t_drive_item it;
        it.action   = action;
        it.setpoint = sp;
        it.measured = meas;
        it.sel      = sel;
        it.target   = tgt;
        pending_items.push_back(it);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_rate();
        case ($urandom_range(3))
            0: return DATA_W'($urandom);
            1: return DATA_W'(int'($urandom_range(1024)) - 512);
            2: return DATA_W'(int'($urandom_range(8192)) - 4096);
            default: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_target();
        int r;
        r = $urandom_range(99);
        if (r < 80) return DATA_W'(int'($urandom_range(51200)) - 25600);
        if (r < 90) return $urandom_range(1) ? 16'sd25600 : -16'sd25600;
        return DATA_W'($urandom);
    endfunction

    function automatic void push_random_item();
        int r;
        logic [1:0] act;
        r = $urandom_range(99);
        if (r < 40) act = ACT_RAMP;
        else if (r < 75) act = ACT_PID;
        else if (r < 95) act = ACT_SET;
        else act = ACT_UNUSED;
        push_item(act, pick_rate(), pick_rate(), 1'($urandom), pick_target());
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_KP:         cfg_model.kp         = data[DATA_W-1:0];
            CFG_KI:         cfg_model.ki         = data[DATA_W-1:0];
            CFG_KD:         cfg_model.kd         = data[KD_W-1:0];
            CFG_P_LIMIT:    cfg_model.p_limit    = data[DATA_W-1:0];
            CFG_I_LIMIT:    cfg_model.i_limit    = data[DATA_W-1:0];
            CFG_D_LIMIT:    cfg_model.d_limit    = data[DATA_W-1:0];
            CFG_ACCEL_STEP: cfg_model.accel_step = data[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input longint kp, input longint ki, input longint kd,
                             input longint pl, input longint il, input longint dl,
                             input longint acc);
        write_reg(CFG_KP, CFG_W'(kp));
        write_reg(CFG_KI, CFG_W'(ki));
        write_reg(CFG_KD, CFG_W'(kd));
        write_reg(CFG_P_LIMIT, CFG_W'(pl));
        write_reg(CFG_I_LIMIT, CFG_W'(il));
        write_reg(CFG_D_LIMIT, CFG_W'(dl));
        write_reg(CFG_ACCEL_STEP, CFG_W'(acc));
    endtask

    // wait until every queued item went in and every report came back
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_items.size() != 0 || i_in_valid || due_reports.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // driver: present the next item once the current one has transferred
    always @(negedge i_clk) begin : driver
        t_drive_item nxt;
        if (!i_in_valid || in_fire) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_items.pop_front();
                i_in_valid       <= 1'b1;
                i_action         <= nxt.action;
                i_rate_setpoint  <= nxt.setpoint;
                i_rate_measured  <= nxt.measured;
                i_motor_select   <= nxt.sel;
                i_target_percent <= nxt.target;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // monitor: check each result transfer, predict each input transfer
    always @(posedge i_clk) begin : monitor
        t_drive_report want;
        t_drive_item   it;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= i_in_valid && !o_in_stall;
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (due_reports.size() == 0) begin
                    $error("result transfer with no item outstanding");
                    err_count++;
                end else begin
                    want = due_reports.pop_front();
                    check_field("left_duty", want.left_duty, o_left_duty);
                    check_field("left_forward", want.left_fwd, o_left_forward);
                    check_field("right_duty", want.right_duty, o_right_duty);
                    check_field("right_forward", want.right_fwd, o_right_forward);
                    check_field("left_goal", want.left_goal, o_left_goal);
                    check_field("right_goal", want.right_goal, o_right_goal);
                    report_count++;
                end
            end
            if (i_in_valid && o_in_stall === 1'b0) begin
                it.action   = i_action;
                it.setpoint = i_rate_setpoint;
                it.measured = i_rate_measured;
                it.sel      = i_motor_select;
                it.target   = i_target_percent;
                due_reports.push_back(step_drive_model(it));
                item_count++;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("no transfer for %0d cycles", QUIET_LIMIT);
        $display("tb_pid_differential_drive_ramp_top: errors");
        $finish;
    end

    initial begin : sequencer
        int ph, n;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset defaults, no idling
        push_item(ACT_RAMP, 16'sd0, 16'sd0, 1'b0, 16'sd0);
        push_item(ACT_PID, 16'sd256, 16'sd0, 1'b0, 16'sd0);
        push_item(ACT_RAMP, 16'sd0, 16'sd0, 1'b0, 16'sd0);
        push_item(ACT_RAMP, 16'sd0, 16'sd0, 1'b0, 16'sd0);
        push_item(ACT_PID, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0);
        push_item(ACT_RAMP, 16'sd0, 16'sd0, 1'b0, 16'sd0);
        push_item(ACT_PID, 16'sh8000, 16'sh7FFF, 1'b1, 16'sd0);
        push_item(ACT_PID, 16'sd0, 16'sd0, 1'b0, 16'sd0);
        push_item(ACT_SET, 16'sd0, 16'sd0, 1'b0, 16'sd25600);
        push_item(ACT_SET, 16'sd0, 16'sd0, 1'b1, -16'sd25600);
        push_item(ACT_RAMP, 16'sd0, 16'sd0, 1'b0, 16'sd0);
        push_item(ACT_RAMP, 16'sd0, 16'sd0, 1'b0, 16'sd0);
        // out-of-range targets saturate
        push_item(ACT_SET, 16'sd0, 16'sd0, 1'b0, 16'sh7FFF);
        push_item(ACT_SET, 16'sd0, 16'sd0, 1'b1, 16'sh8000);
        push_item(ACT_UNUSED, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh7FFF);
        push_item(ACT_SET, 16'sd0, 16'sd0, 1'b0, -16'sd25600);
        push_item(ACT_SET, 16'sd0, 16'sd0, 1'b1, 16'sd25600);
        for (n = 0; n < 4; n++)
            push_item(ACT_RAMP, 16'sd0, 16'sd0, 1'b0, 16'sd0);
        push_item(ACT_PID, 16'sh8000, 16'sh8000, 1'b0, 16'sd0);
        push_item(ACT_UNUSED, 16'sd0, 16'sd0, 1'b0, 16'sd0);
        wait_drained();

        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: write_all(65535, 65535, 24'hFFFFFF, 65535, 65535, 65535, 25600);
                1: begin
                    // zero gains and limits, frozen commands
                    write_all(0, 0, 0, 0, 0, 0, 0);
                    write_reg(CFG_IDX_NONE, CFG_W'($urandom));
                end
                2: write_all($urandom_range(4096), $urandom_range(2048),
                             $urandom_range(1 << 20), $urandom_range(65535),
                             $urandom_range(65535), $urandom_range(65535),
                             $urandom_range(1, 4000));
                3: write_all(CFG_RESET.kp, CFG_RESET.ki, CFG_RESET.kd, CFG_RESET.p_limit,
                             CFG_RESET.i_limit, CFG_RESET.d_limit, CFG_RESET.accel_step);
                default: write_all($urandom_range(65535), $urandom_range(65535),
                                   $urandom_range(24'hFFFFFF), $urandom_range(65535),
                                   $urandom_range(65535), $urandom_range(65535),
                                   $urandom_range(25600));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 46; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 46; end
                default: begin send_idle_pct = 12; stall_pct = 12; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                push_random_item();
            wait_drained();
        end

        $display("%0d items sent, %0d results checked", item_count, report_count);
        $display("%0d register settings, idle and stall mixes from none to 46 percent",
                 N_PHASES + 1);
        if (err_count == 0)
            $display("tb_pid_differential_drive_ramp_top: clean");
        else
            $display("tb_pid_differential_drive_ramp_top: errors");
        $finish;
    end

endmodule
